### hw/rtl/lnpd_pkg.sv
// Shared types and constants of the line-number program decoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lnpd_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIV,
      ST_MUL,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      PH_OP,
      PH_ULEB,
      PH_SLEB,
      PH_FIXED,
      PH_EXTLEN,
      PH_EXTCODE,
      PH_SETADDR,
      PH_DISCRIM
   } phase_type;

   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_STD  = 2'd1;
   localparam logic [1:0] ERR_EXT  = 2'd2;

   localparam logic [2:0] CSR_MIN_INSN  = 3'd0;
   localparam logic [2:0] CSR_DEF_STMT  = 3'd1;
   localparam logic [2:0] CSR_LINE_BASE = 3'd2;
   localparam logic [2:0] CSR_LINE_RNG  = 3'd3;
   localparam logic [2:0] CSR_OP_BASE   = 3'd4;
   localparam logic [2:0] CSR_ADDR_BYTES = 3'd5;

   localparam logic [7:0] OP_EXTENDED   = 8'd0;
   localparam logic [7:0] OP_COPY       = 8'd1;
   localparam logic [7:0] OP_ADV_PC     = 8'd2;
   localparam logic [7:0] OP_ADV_LINE   = 8'd3;
   localparam logic [7:0] OP_SET_FILE   = 8'd4;
   localparam logic [7:0] OP_SET_COLUMN = 8'd5;
   localparam logic [7:0] OP_NEG_STMT   = 8'd6;
   localparam logic [7:0] OP_SET_BB     = 8'd7;
   localparam logic [7:0] OP_CONST_ADD  = 8'd8;
   localparam logic [7:0] OP_FIXED_ADV  = 8'd9;
   localparam logic [7:0] OP_SET_PE     = 8'd10;
   localparam logic [7:0] OP_SET_EB     = 8'd11;

   localparam logic [7:0] EXT_END_SEQ   = 8'd1;
   localparam logic [7:0] EXT_SET_ADDR  = 8'd2;
   localparam logic [7:0] EXT_SET_DISC  = 8'd4;

endpackage
`default_nettype wire

### hw/rtl/line_number_program_decoder_core.sv
// Line-number program decoder: byte-serial line-table machine with one shared
// divide/multiply sequencer. Depends on lnpd_pkg.
// A request is taken while idle and decoded in the next cycle; a special opcode adds 8 division
// steps by the line range, 8 shift-add steps by the instruction length and 1 emit, or the emit
// alone at a zero range; advance_pc and const_add_pc use the sequencer too. A new byte waits
// for the last to be done, even behind a held result. Sync reset restores all defaults.
`timescale 1ns / 1ps
`default_nettype none
module line_number_program_decoder_core import lnpd_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_program_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [63:0]      rsp_row_address,
   output logic [31:0]      rsp_row_line,
   output logic [31:0]      rsp_row_column,
   output logic [31:0]      rsp_row_file,
   output logic             rsp_row_is_stmt,
   output logic             rsp_row_blk_start,
   output logic             rsp_row_seq_end,
   output logic             rsp_row_prolog_done,
   output logic             rsp_row_epilog_start,
   output logic [1:0]       rsp_error_code,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [7:0]  csr_data
);

   // configuration
   logic [7:0] min_insn_ff, lbase_ff, lrange_ff, op_base_ff;
   logic       def_stmt_ff;
   logic [3:0] addr_bytes_ff;

   state_type  st_ff, st_in;
   phase_type  ph_ff, ph_in;
   logic [7:0]  byte_ff, byte_in;
   logic [7:0]  pend_ff, pend_in;
   logic [63:0] accum_ff, accum_in;
   logic [6:0]  shift_ff, shift_in;
   logic [3:0]  ocnt_ff, ocnt_in;
   logic        err_ff, err_in;
   logic [63:0] addr_ff, addr_in;
   logic [31:0] line_ff, line_in, col_ff, col_in, file_ff, file_in;
   logic        stmt_ff, stmt_in, bb_ff, bb_in, pe_ff, pe_in, eb_ff, eb_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [7:0]  quo_ff, quo_in, rem_ff, rem_in;
   logic [63:0] mcand_ff, mcand_in, prod_ff, prod_in;
   logic        spec_ff, spec_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] o_addr_ff, o_addr_in;
   logic [31:0] o_line_ff, o_line_in, o_col_ff, o_col_in, o_file_ff, o_file_in;
   logic [4:0]  o_flags_ff, o_flags_in;
   logic [1:0]  o_err_ff, o_err_in;

   logic        out_free;
   logic        leb_on, leb_last;
   logic [63:0] leb_acc;
   logic [6:0]  leb_sh;
   logic [63:0] sacc;
   logic [7:0]  adj;
   logic [8:0]  trial;
   logic        qbit;
   logic [7:0]  rem_nx, quo_nx;
   logic [63:0] fixed_acc, set_acc;
   logic [3:0]  ocnt_nx;

   assign csr_ready = 1'b1;
   assign req_ready = (st_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_insn_ff   <= 8'd1;
         def_stmt_ff   <= 1'b1;
         lbase_ff      <= 8'hfb;
         lrange_ff     <= 8'd14;
         op_base_ff    <= 8'd13;
         addr_bytes_ff <= 4'd8;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MIN_INSN:   min_insn_ff   <= csr_data;
            CSR_DEF_STMT:   def_stmt_ff   <= csr_data[0];
            CSR_LINE_BASE:  lbase_ff      <= csr_data;
            CSR_LINE_RNG:   lrange_ff     <= csr_data;
            CSR_OP_BASE:    op_base_ff    <= csr_data;
            CSR_ADDR_BYTES: addr_bytes_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      // operand helpers on the held byte
      leb_on   = (shift_ff < 7'd64);
      leb_acc  = accum_ff | (leb_on ? ({57'd0, byte_ff[6:0]} << shift_ff[5:0]) : 64'd0);
      leb_sh   = leb_on ? shift_ff + 7'd7 : shift_ff;
      leb_last = !byte_ff[7];
      sacc     = leb_acc;
      if (byte_ff[6] && (leb_sh < 7'd64))
         sacc = leb_acc | ({64{1'b1}} << leb_sh[5:0]);
      fixed_acc = accum_ff | ((ocnt_ff != 4'd0) ? {48'd0, byte_ff, 8'd0} : {56'd0, byte_ff});
      set_acc   = accum_ff;
      if (ocnt_ff < 4'd8)
         set_acc = accum_ff | ({56'd0, byte_ff} << {ocnt_ff[2:0], 3'd0});
      ocnt_nx = ocnt_ff + 4'd1;
      adj     = byte_ff - op_base_ff;
      // one restoring division step
      trial   = {rem_ff, quo_ff[7]};
      qbit    = (trial >= {1'b0, lrange_ff});
      rem_nx  = qbit ? 8'(trial - {1'b0, lrange_ff}) : trial[7:0];
      quo_nx  = {quo_ff[6:0], qbit};
   end

   always_comb begin
      st_in = st_ff;   ph_in = ph_ff;   byte_in = byte_ff;  pend_in = pend_ff;
      accum_in = accum_ff;  shift_in = shift_ff;  ocnt_in = ocnt_ff;  err_in = err_ff;
      addr_in = addr_ff;  line_in = line_ff;  col_in = col_ff;  file_in = file_ff;
      stmt_in = stmt_ff;  bb_in = bb_ff;  pe_in = pe_ff;  eb_in = eb_ff;
      cnt_in = cnt_ff;  quo_in = quo_ff;  rem_in = rem_ff;
      mcand_in = mcand_ff;  prod_in = prod_ff;  spec_in = spec_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      o_addr_in = o_addr_ff;  o_line_in = o_line_ff;  o_col_in = o_col_ff;
      o_file_in = o_file_ff;  o_flags_in = o_flags_ff;  o_err_in = o_err_ff;

      case (st_ff)
         ST_IDLE: begin
            if (req_valid) begin
               byte_in = req_program_byte;
               st_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            st_in = ST_IDLE;
            if (!err_ff) begin
               case (ph_ff)
                  PH_OP: begin
                     if (byte_ff >= op_base_ff) begin
                        spec_in = 1'b1;
                        if (lrange_ff == 8'd0) begin
                           line_in = line_ff + {24'd0, adj} + {{24{lbase_ff[7]}}, lbase_ff};
                           st_in   = ST_EMIT;
                        end else begin
                           quo_in = adj;  rem_in = 8'd0;  cnt_in = 3'd0;
                           st_in  = ST_DIV;
                        end
                     end else begin
                        case (byte_ff)
                           OP_EXTENDED: begin
                              ph_in = PH_EXTLEN;  accum_in = 64'd0;
                              shift_in = 7'd0;  ocnt_in = 4'd0;
                           end
                           OP_COPY: begin
                              if (out_free) begin
                                 rsp_valid_in = 1'b1;
                                 o_addr_in = addr_ff;  o_line_in = line_ff;
                                 o_col_in = col_ff;  o_file_in = file_ff;
                                 o_flags_in = {eb_ff, pe_ff, 1'b0, bb_ff, stmt_ff};
                                 o_err_in = ERR_NONE;
                                 bb_in = 1'b0;  pe_in = 1'b0;  eb_in = 1'b0;
                              end else begin
                                 st_in = ST_EXEC;
                              end
                           end
                           OP_ADV_PC, OP_SET_FILE, OP_SET_COLUMN: begin
                              pend_in = byte_ff;  ph_in = PH_ULEB;  accum_in = 64'd0;
                              shift_in = 7'd0;  ocnt_in = 4'd0;
                           end
                           OP_ADV_LINE: begin
                              ph_in = PH_SLEB;  accum_in = 64'd0;
                              shift_in = 7'd0;  ocnt_in = 4'd0;
                           end
                           OP_NEG_STMT: stmt_in = !stmt_ff;
                           OP_SET_BB:   bb_in = 1'b1;
                           OP_CONST_ADD: begin
                              spec_in = 1'b0;
                              if (lrange_ff != 8'd0) begin
                                 quo_in = 8'd255 - op_base_ff;  rem_in = 8'd0;
                                 cnt_in = 3'd0;  st_in = ST_DIV;
                              end
                           end
                           OP_FIXED_ADV: begin
                              ph_in = PH_FIXED;  accum_in = 64'd0;
                              shift_in = 7'd0;  ocnt_in = 4'd0;
                           end
                           OP_SET_PE: pe_in = 1'b1;
                           OP_SET_EB: eb_in = 1'b1;
                           default: begin
                              if (out_free) begin
                                 rsp_valid_in = 1'b1;
                                 o_addr_in = 64'd0;  o_line_in = 32'd0;  o_col_in = 32'd0;
                                 o_file_in = 32'd0;  o_flags_in = 5'd0;  o_err_in = ERR_STD;
                                 err_in = 1'b1;
                              end else begin
                                 st_in = ST_EXEC;
                              end
                           end
                        endcase
                     end
                  end
                  PH_ULEB: begin
                     accum_in = leb_acc;  shift_in = leb_sh;
                     if (leb_last) begin
                        ph_in = PH_OP;
                        if (pend_ff == OP_ADV_PC) begin
                           spec_in = 1'b0;  mcand_in = leb_acc;  prod_in = addr_ff;
                           cnt_in = 3'd0;  st_in = ST_MUL;
                        end else if (pend_ff == OP_SET_FILE) begin
                           file_in = leb_acc[31:0];
                        end else begin
                           col_in = leb_acc[31:0];
                        end
                     end
                  end
                  PH_SLEB: begin
                     accum_in = leb_acc;  shift_in = leb_sh;
                     if (leb_last) begin
                        line_in = line_ff + sacc[31:0];
                        ph_in   = PH_OP;
                     end
                  end
                  PH_FIXED: begin
                     accum_in = fixed_acc;
                     if (ocnt_ff != 4'd0) begin
                        addr_in = addr_ff + {48'd0, fixed_acc[15:0]};
                        ph_in   = PH_OP;
                     end else begin
                        ocnt_in = 4'd1;
                     end
                  end
                  PH_EXTLEN: begin
                     accum_in = leb_acc;  shift_in = leb_sh;
                     if (leb_last) ph_in = PH_EXTCODE;
                  end
                  PH_EXTCODE: begin
                     case (byte_ff)
                        EXT_END_SEQ: begin
                           if (out_free) begin
                              rsp_valid_in = 1'b1;
                              o_addr_in = addr_ff;  o_line_in = line_ff;
                              o_col_in = col_ff;  o_file_in = file_ff;
                              o_flags_in = {eb_ff, pe_ff, 1'b1, bb_ff, stmt_ff};
                              o_err_in = ERR_NONE;
                              addr_in = 64'd0;  line_in = 32'd1;  col_in = 32'd0;
                              file_in = 32'd1;  stmt_in = def_stmt_ff;
                              bb_in = 1'b0;  pe_in = 1'b0;  eb_in = 1'b0;
                              ph_in = PH_OP;
                           end else begin
                              st_in = ST_EXEC;
                           end
                        end
                        EXT_SET_ADDR: begin
                           if (addr_bytes_ff == 4'd0) begin
                              addr_in = 64'd0;  ph_in = PH_OP;
                           end else begin
                              ph_in = PH_SETADDR;  accum_in = 64'd0;
                              shift_in = 7'd0;  ocnt_in = 4'd0;
                           end
                        end
                        EXT_SET_DISC: begin
                           ph_in = PH_DISCRIM;  accum_in = 64'd0;
                           shift_in = 7'd0;  ocnt_in = 4'd0;
                        end
                        default: begin
                           if (out_free) begin
                              rsp_valid_in = 1'b1;
                              o_addr_in = 64'd0;  o_line_in = 32'd0;  o_col_in = 32'd0;
                              o_file_in = 32'd0;  o_flags_in = 5'd0;  o_err_in = ERR_EXT;
                              err_in = 1'b1;  ph_in = PH_OP;
                           end else begin
                              st_in = ST_EXEC;
                           end
                        end
                     endcase
                  end
                  PH_SETADDR: begin
                     accum_in = set_acc;  ocnt_in = ocnt_nx;
                     if (ocnt_nx >= addr_bytes_ff) begin
                        addr_in = set_acc;  ph_in = PH_OP;
                     end
                  end
                  PH_DISCRIM: begin
                     accum_in = leb_acc;  shift_in = leb_sh;
                     if (leb_last) ph_in = PH_OP;
                  end
                  default: ph_in = PH_OP;
               endcase
            end
         end
         ST_DIV: begin
            quo_in = quo_nx;  rem_in = rem_nx;  cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd7) begin
               if (spec_ff)
                  line_in = line_ff + {24'd0, rem_nx} + {{24{lbase_ff[7]}}, lbase_ff};
               mcand_in = {56'd0, quo_nx};  prod_in = addr_ff;
               cnt_in = 3'd0;  st_in = ST_MUL;
            end
         end
         ST_MUL: begin
            // shift-add over the bits of the instruction length, starting from the address
            if (min_insn_ff[cnt_ff]) prod_in = prod_ff + mcand_ff;
            mcand_in = {mcand_ff[62:0], 1'b0};
            cnt_in   = cnt_ff + 3'd1;
            if (cnt_ff == 3'd7) begin
               addr_in = min_insn_ff[cnt_ff] ? prod_ff + mcand_ff : prod_ff;
               st_in   = spec_ff ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               o_addr_in = addr_ff;  o_line_in = line_ff;
               o_col_in = col_ff;  o_file_in = file_ff;
               o_flags_in = {eb_ff, pe_ff, 1'b0, bb_ff, stmt_ff};
               o_err_in = ERR_NONE;
               bb_in = 1'b0;  pe_in = 1'b0;  eb_in = 1'b0;
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;  ph_ff <= PH_OP;  pend_ff <= 8'd0;
         accum_ff <= 64'd0;  shift_ff <= 7'd0;  ocnt_ff <= 4'd0;  err_ff <= 1'b0;
         addr_ff <= 64'd0;  line_ff <= 32'd1;  col_ff <= 32'd0;  file_ff <= 32'd1;
         stmt_ff <= 1'b1;  bb_ff <= 1'b0;  pe_ff <= 1'b0;  eb_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;  spec_ff <= 1'b0;
      end else begin
         st_ff <= st_in;  ph_ff <= ph_in;  pend_ff <= pend_in;
         accum_ff <= accum_in;  shift_ff <= shift_in;  ocnt_ff <= ocnt_in;  err_ff <= err_in;
         addr_ff <= addr_in;  line_ff <= line_in;  col_ff <= col_in;  file_ff <= file_in;
         stmt_ff <= stmt_in;  bb_ff <= bb_in;  pe_ff <= pe_in;  eb_ff <= eb_in;
         rsp_valid_ff <= rsp_valid_in;  spec_ff <= spec_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;  cnt_ff <= cnt_in;  quo_ff <= quo_in;  rem_ff <= rem_in;
      mcand_ff <= mcand_in;  prod_ff <= prod_in;
      o_addr_ff <= o_addr_in;  o_line_ff <= o_line_in;  o_col_ff <= o_col_in;
      o_file_ff <= o_file_in;  o_flags_ff <= o_flags_in;  o_err_ff <= o_err_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_row_address      = o_addr_ff;
   assign rsp_row_line         = o_line_ff;
   assign rsp_row_column       = o_col_ff;
   assign rsp_row_file         = o_file_ff;
   assign rsp_row_is_stmt      = o_flags_ff[0];
   assign rsp_row_blk_start    = o_flags_ff[1];
   assign rsp_row_seq_end      = o_flags_ff[2];
   assign rsp_row_prolog_done  = o_flags_ff[3];
   assign rsp_row_epilog_start = o_flags_ff[4];
   assign rsp_error_code       = o_err_ff;

`ifndef SYNTH
   a_no_rsp_after_error: assert property (@(posedge clock) disable iff (reset)
      err_ff && !rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result raised after error latch");
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(st_ff == ST_EXEC || st_ff == ST_EMIT))
      else $error("result loaded outside decode or emit");
   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_error_code != 2'd3)
      else $error("bad error code");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_error_code != ERR_NONE |-> rsp_row_line == 32'd0 && !rsp_row_is_stmt)
      else $error("error result carries row data");
`endif

endmodule
`default_nettype wire

### sim/line_number_program_decoder_checker.sv
// Watches the request, result and register channels of the line-number program
// decoder, predicts every emitted row and compares it. Depends on lnpd_pkg.
`timescale 1ns / 1ps
module line_number_program_decoder_checker import lnpd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_program_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [63:0] rsp_row_address,
   input  logic [31:0] rsp_row_line,
   input  logic [31:0] rsp_row_column,
   input  logic [31:0] rsp_row_file,
   input  logic        rsp_row_is_stmt,
   input  logic        rsp_row_blk_start,
   input  logic        rsp_row_seq_end,
   input  logic        rsp_row_prolog_done,
   input  logic        rsp_row_epilog_start,
   input  logic [1:0]  rsp_error_code,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_data,
   output int          fail_count,
   output int          pending
);

   typedef struct packed {
      logic [63:0] address;
      logic [31:0] line;
      logic [31:0] column;
      logic [31:0] file;
      logic        is_stmt;
      logic        blk_start;
      logic        end_seq;
      logic        prolog_done;
      logic        epilog_start;
      logic [1:0]  err;
   } row_type;

   row_type rows_due[$];

   // configuration copy
   logic [7:0] min_insn, lbase, lrange, op_base;
   logic       def_stmt;
   logic [3:0] addr_bytes;

   // line-table machine copy
   logic [63:0] addr_q, accum;
   logic [31:0] line_q, col_q, file_q;
   logic        stmt_f, bb_f, pe_f, eb_f, err_latched;
   phase_type   phase;
   logic [7:0]  op_held;
   logic [6:0]  shift;
   logic [3:0]  count;

   assign pending = rows_due.size();

   task automatic clear_rows();
      addr_q = '0; line_q = 32'd1; col_q = '0; file_q = 32'd1;
      stmt_f = def_stmt; bb_f = 1'b0; pe_f = 1'b0; eb_f = 1'b0;
   endtask

   task automatic begin_operand(input phase_type p);
      phase = p; accum = '0; shift = '0; count = '0;
   endtask

   function automatic row_type cur_row(input logic es);
      row_type r;
      r = '{address: addr_q, line: line_q, column: col_q, file: file_q, is_stmt: stmt_f,
            blk_start: bb_f, end_seq: es, prolog_done: pe_f, epilog_start: eb_f,
            err: ERR_NONE};
      return r;
   endfunction

   task automatic queue_row();
      rows_due = {rows_due, cur_row(1'b0)};
      bb_f = 1'b0; pe_f = 1'b0; eb_f = 1'b0;
   endtask

   task automatic queue_error(input logic [1:0] code);
      row_type r;
      r = '0;
      r.err = code;
      rows_due = {rows_due, r};
      err_latched = 1'b1;
      phase = PH_OP;
   endtask

   // true on the last byte of a LEB128 operand
   function automatic bit leb_take(input logic [7:0] b);
      if (shift < 7'd64) begin
         accum |= 64'(b[6:0]) << shift;
         shift += 7'd7;
      end
      return !b[7];
   endfunction

   task automatic decode_byte(input logic [7:0] b);
      logic [7:0] adj;
      logic [7:0] q, r;
      if (err_latched) return;
      case (phase)
         PH_OP: begin
            if (b >= op_base) begin
               adj = b - op_base;
               q = (lrange != 8'd0) ? adj / lrange : 8'd0;
               r = (lrange != 8'd0) ? adj % lrange : adj;
               addr_q += 64'(q) * 64'(min_insn);
               line_q += 32'(r) + 32'(signed'(lbase));
               queue_row();
            end else begin
               case (b)
                  OP_EXTENDED: begin_operand(PH_EXTLEN);
                  OP_COPY: queue_row();
                  OP_ADV_PC, OP_SET_FILE, OP_SET_COLUMN: begin
                     op_held = b;
                     begin_operand(PH_ULEB);
                  end
                  OP_ADV_LINE: begin_operand(PH_SLEB);
                  OP_NEG_STMT: stmt_f = !stmt_f;
                  OP_SET_BB: bb_f = 1'b1;
                  OP_CONST_ADD: begin
                     q = (lrange != 8'd0) ? (8'd255 - op_base) / lrange : 8'd0;
                     addr_q += 64'(q) * 64'(min_insn);
                  end
                  OP_FIXED_ADV: begin_operand(PH_FIXED);
                  OP_SET_PE: pe_f = 1'b1;
                  OP_SET_EB: eb_f = 1'b1;
                  default: queue_error(ERR_STD);
               endcase
            end
         end
         PH_ULEB: if (leb_take(b)) begin
            if (op_held == OP_ADV_PC) addr_q += accum * 64'(min_insn);
            else if (op_held == OP_SET_FILE) file_q = accum[31:0];
            else col_q = accum[31:0];
            phase = PH_OP;
         end
         PH_SLEB: if (leb_take(b)) begin
            if (b[6] && shift < 7'd64) accum |= ~64'd0 << shift;
            line_q += accum[31:0];
            phase = PH_OP;
         end
         PH_FIXED: begin
            if (count != 4'd0) begin
               accum |= 64'(b) << 8;
               addr_q += accum & 64'hffff;
               phase = PH_OP;
            end else begin
               accum |= 64'(b);
               count = 4'd1;
            end
         end
         PH_EXTLEN: if (leb_take(b)) phase = PH_EXTCODE;
         PH_EXTCODE: begin
            if (b == EXT_END_SEQ) begin
               rows_due = {rows_due, cur_row(1'b1)};
               clear_rows();
               phase = PH_OP;
            end else if (b == EXT_SET_ADDR) begin
               if (addr_bytes == 4'd0) begin
                  addr_q = '0;
                  phase = PH_OP;
               end else begin
                  begin_operand(PH_SETADDR);
               end
            end else if (b == EXT_SET_DISC) begin
               begin_operand(PH_DISCRIM);
            end else begin
               queue_error(ERR_EXT);
            end
         end
         PH_SETADDR: begin
            if (count < 4'd8) accum |= 64'(b) << {count[2:0], 3'b000};
            count = count + 4'd1;
            if (count >= addr_bytes) begin
               addr_q = accum;
               phase = PH_OP;
            end
         end
         PH_DISCRIM: if (leb_take(b)) phase = PH_OP;
         default: phase = PH_OP;
      endcase
   endtask

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %0h, want %0h at %0t", field, got, want, $realtime);
      fail_count++;
   endtask

   task automatic check_row();
      row_type w;
      if (rows_due.size() == 0) begin
         $display("row with nothing outstanding at %0t", $realtime);
         fail_count++;
         return;
      end
      w = rows_due.pop_front();
      if (rsp_row_address !== w.address) report_mismatch("address", rsp_row_address, w.address);
      if (rsp_row_line !== w.line)
         report_mismatch("line", 64'(rsp_row_line), 64'(w.line));
      if (rsp_row_column !== w.column)
         report_mismatch("column", 64'(rsp_row_column), 64'(w.column));
      if (rsp_row_file !== w.file)
         report_mismatch("file", 64'(rsp_row_file), 64'(w.file));
      if (rsp_row_is_stmt !== w.is_stmt)
         report_mismatch("is_stmt", 64'(rsp_row_is_stmt), 64'(w.is_stmt));
      if (rsp_row_blk_start !== w.blk_start)
         report_mismatch("blk_start", 64'(rsp_row_blk_start), 64'(w.blk_start));
      if (rsp_row_seq_end !== w.end_seq)
         report_mismatch("seq_end", 64'(rsp_row_seq_end), 64'(w.end_seq));
      if (rsp_row_prolog_done !== w.prolog_done)
         report_mismatch("prolog_done", 64'(rsp_row_prolog_done), 64'(w.prolog_done));
      if (rsp_row_epilog_start !== w.epilog_start)
         report_mismatch("epilog_start", 64'(rsp_row_epilog_start), 64'(w.epilog_start));
      if (rsp_error_code !== w.err)
         report_mismatch("error_code", 64'(rsp_error_code), 64'(w.err));
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      if (reset) begin
         min_insn = 8'd1; def_stmt = 1'b1; lbase = 8'hfb; lrange = 8'd14; op_base = 8'd13;
         addr_bytes = 4'd8;
         clear_rows();
         phase = PH_OP; op_held = '0; accum = '0; shift = '0; count = '0;
         err_latched = 1'b0;
         rows_due.delete();
      end else begin
         // compare before predicting: a request cannot answer at its own edge
         if (rsp_valid && rsp_ready) check_row();
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MIN_INSN:   min_insn = csr_data;
               CSR_DEF_STMT:   def_stmt = csr_data[0];
               CSR_LINE_BASE:  lbase = csr_data;
               CSR_LINE_RNG:   lrange = csr_data;
               CSR_OP_BASE:    op_base = csr_data;
               CSR_ADDR_BYTES: addr_bytes = csr_data[3:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) decode_byte(req_program_byte);
      end
   end

endmodule

### sim/line_number_program_decoder_core_tb.sv
// Stimulus and verdict for the line-number program decoder: well-formed random
// programs under several settings and idling patterns. Depends on lnpd_pkg,
// line_number_program_decoder_core and line_number_program_decoder_checker.
`timescale 1ns / 1ps
module line_number_program_decoder_core_tb;
   import lnpd_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int SETTLE = 40;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0, req_ready;
   logic [7:0]  req_program_byte = '0;
   logic        rsp_valid, rsp_ready = 0;
   logic [63:0] rsp_row_address;
   logic [31:0] rsp_row_line, rsp_row_column, rsp_row_file;
   logic        rsp_row_is_stmt, rsp_row_blk_start, rsp_row_seq_end;
   logic        rsp_row_prolog_done, rsp_row_epilog_start;
   logic [1:0]  rsp_error_code;
   logic        csr_valid = 0, csr_ready;
   logic [2:0]  csr_index = '0;
   logic [7:0]  csr_data = '0;

   int fail_count, pending;
   int send_idle_pct = 0, stall_pct = 0;
   logic long_hold = 0;
   int hold_cnt = 0;
   int cycles = 0;
   logic [7:0] cur_op_base = 13;
   logic [3:0] cur_addr_bytes = 8;

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   line_number_program_decoder_core u_top (.*);

   line_number_program_decoder_checker u_check (.*);

   // receiver: random stalls, plus one long hold-off while long_hold is up
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
         hold_cnt <= 0;
      end else if (long_hold && hold_cnt < 400) begin
         hold_cnt <= hold_cnt + 1;
         rsp_ready <= 0;
      end else begin
         if (!long_hold) hold_cnt <= 0;
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1;
      req_program_byte <= b;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // leaves csr_valid up; the caller drops it after the last write
   task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_regs(input logic [7:0] mil, input logic stmt, input logic [7:0] lb,
                           input logic [7:0] lr, input logic [7:0] ob, input logic [3:0] ab);
      write_reg(CSR_MIN_INSN, mil);
      write_reg(CSR_DEF_STMT, {7'd0, stmt});
      write_reg(CSR_LINE_BASE, lb);
      write_reg(CSR_LINE_RNG, lr);
      write_reg(CSR_OP_BASE, ob);
      write_reg(CSR_ADDR_BYTES, {4'd0, ab});
      csr_valid <= 0;
      cur_op_base = ob;
      cur_addr_bytes = ab;
   endtask

   // LEB128 operand of n bytes with random payload
   task automatic send_leb(input int n);
      logic [7:0] b;
      for (int i = 0; i < n; i++) begin
         b = 8'($urandom);
         b[7] = (i != n - 1);
         send_byte(b);
      end
   endtask

   function automatic int leb_len();
      return ($urandom_range(9) == 0) ? $urandom_range(11, 4) : $urandom_range(3, 1);
   endfunction

   task automatic send_ext(input logic [7:0] code);
      send_byte(OP_EXTENDED);
      send_leb(($urandom_range(3) == 0) ? 2 : 1);
      send_byte(code);
      if (code == EXT_SET_ADDR)
         for (int i = 0; i < cur_addr_bytes; i++) send_byte(8'($urandom));
      else if (code == EXT_SET_DISC)
         send_leb(leb_len());
   endtask

   task automatic send_std(input logic [7:0] op);
      send_byte(op);
      if (op >= cur_op_base) return;
      case (op)
         OP_ADV_PC, OP_SET_FILE, OP_SET_COLUMN, OP_ADV_LINE: send_leb(leb_len());
         OP_FIXED_ADV: begin
            send_byte(8'($urandom));
            send_byte(8'($urandom));
         end
         default: ;
      endcase
   endtask

   // one well-formed instruction valid for the current opcode base
   task automatic send_instr();
      int pick;
      logic [7:0] code;
      pick = $urandom_range(99);
      if (pick < 40 || cur_op_base == 0) begin
         send_byte(8'($urandom_range(255, cur_op_base)));
      end else if (pick < 82) begin
         send_std(8'($urandom_range(11, 1)));
      end else begin
         case ($urandom_range(2))
            0: code = EXT_END_SEQ;
            1: code = EXT_SET_ADDR;
            default: code = EXT_SET_DISC;
         endcase
         send_ext(code);
      end
   endtask

   task automatic run_phase(input int n, input int idle, input int stall);
      send_idle_pct = idle;
      stall_pct = stall;
      for (int i = 0; i < n; i++) send_instr();
      drain();
   endtask

   initial begin
      logic [7:0] bad;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: every opcode and the operand extremes at default settings
      send_std(OP_COPY);
      send_byte(8'd13);
      send_byte(8'd255);
      send_byte(OP_ADV_PC);
      for (int i = 0; i < 10; i++) send_byte(8'hff);
      send_byte(8'h01);
      send_byte(OP_ADV_LINE);
      send_byte(8'h7f);
      send_byte(OP_ADV_LINE);
      send_byte(8'h80);
      send_byte(8'h40);
      send_std(OP_SET_FILE);
      send_std(OP_SET_COLUMN);
      send_std(OP_NEG_STMT);
      send_std(OP_SET_BB);
      send_std(OP_SET_PE);
      send_std(OP_SET_EB);
      send_byte(OP_COPY);
      send_byte(OP_CONST_ADD);
      send_byte(OP_FIXED_ADV);
      send_byte(8'hff);
      send_byte(8'hff);
      send_byte(OP_COPY);
      send_ext(EXT_SET_ADDR);
      send_ext(EXT_SET_DISC);
      send_ext(EXT_END_SEQ);
      send_byte(OP_COPY);
      drain();

      run_phase(80, 0, 0);
      set_regs(8'd255, 1'b0, 8'h80, 8'd1, 8'd255, 4'd1);
      run_phase(80, 83, 0);
      set_regs(8'd1, 1'b1, 8'h7f, 8'd255, 8'd1, 4'd4);
      run_phase(80, 0, 83);
      set_regs(8'd7, 1'b0, 8'hfd, 8'd12, 8'd10, 4'd0);
      run_phase(80, 38, 38);
      set_regs(8'd2, 1'b1, 8'hff, 8'd0, 8'd13, 4'd15);
      run_phase(80, 0, 0);
      set_regs(8'd4, 1'b1, 8'd5, 8'd3, 8'd0, 4'd8);
      run_phase(80, 83, 0);

      // hold the receiver off while requests keep coming, so the block backs up
      set_regs(8'd1, 1'b0, 8'd0, 8'd1, 8'd13, 4'd8);
      long_hold <= 1;
      send_idle_pct = 0;
      stall_pct = 0;
      for (int i = 0; i < 60; i++) send_instr();
      long_hold <= 0;
      drain();

      set_regs(8'd3, 1'b1, 8'hfb, 8'd14, 8'd13, 4'd2);
      run_phase(80, 0, 83);

      // one error at the end, then bytes that must be ignored
      send_idle_pct = 38;
      stall_pct = 38;
      if ($urandom_range(1)) begin
         send_byte(8'd12);
      end else begin
         bad = 8'($urandom);
         if (bad == EXT_END_SEQ || bad == EXT_SET_ADDR || bad == EXT_SET_DISC) bad = 8'd3;
         send_ext(bad);
      end
      for (int i = 0; i < 12; i++) send_byte(8'($urandom));
      drain();

      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

### files.f
hw/rtl/lnpd_pkg.sv
hw/rtl/line_number_program_decoder_core.sv
sim/line_number_program_decoder_checker.sv
sim/line_number_program_decoder_core_tb.sv
